@@ sv/dws_pkg.sv @@
// Shared types and constants for the deque-with-search block.
// Used by dws_cell and the top level deque_with_search_unit; no dependencies.
`default_nettype none

package dws_pkg;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int POS_W     = 7;
    localparam int STAT_W    = 2;
    // match bits examined per scan cycle
    localparam int CHUNK     = 8;
    localparam int CHUNK_LOG = 3;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_mode MODE_PUSH_FRONT = 3'd0;
    localparam t_mode MODE_PUSH_BACK  = 3'd1;
    localparam t_mode MODE_POP_FRONT  = 3'd2;
    localparam t_mode MODE_POP_BACK   = 3'd3;
    localparam t_mode MODE_FIND_FIRST = 3'd4;
    localparam t_mode MODE_FIND_LAST  = 3'd5;
    localparam t_mode MODE_TOTALS     = 3'd6;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_FULL  = 2'd1;
    localparam t_status STAT_EMPTY = 2'd2;

    // one operation broadcast to every cell of the chain
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/dws_cell.sv @@
// One storage cell of the deque chain: an entry, its occupied flag and a key compare.
// Depends on dws_pkg for the data type and the control struct.
`default_nettype none

module dws_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire dws_pkg::t_cell_ctl  i_ctl,
    input  wire dws_pkg::t_data      i_key,
    input  wire dws_pkg::t_data      i_value,
    input  wire dws_pkg::t_data      i_prev_data,
    input  wire                      i_prev_occ,
    input  wire dws_pkg::t_data      i_next_data,
    input  wire                      i_next_occ,
    output dws_pkg::t_data           o_data,
    output logic                     o_occ,
    output logic                     o_hit
);

    dws_pkg::t_data r_data;
    logic           r_occ;
    dws_pkg::t_data n_data;
    logic           n_occ;

    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        if (i_ctl.push_front) begin
            n_data = i_prev_data;
            n_occ  = i_prev_occ;
        end else if (i_ctl.push_back) begin
            // first empty cell takes the new word
            if (!r_occ && i_prev_occ) begin
                n_data = i_value;
                n_occ  = 1'b1;
            end
        end else if (i_ctl.pop_front) begin
            n_data = i_next_data;
            n_occ  = i_next_occ;
        end else if (i_ctl.pop_back) begin
            if (r_occ && !i_next_occ) begin
                n_occ = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_data = r_data;
    assign o_occ  = r_occ;
    assign o_hit  = r_occ && (r_data == i_key);

endmodule

`default_nettype wire

@@ sv/deque_with_search_unit.sv @@
// Bounded double-ended queue of signed 32-bit words with search and running total.
// A chain of dws_cell instances holds the entries; uses dws_pkg.
//
// Usage:
//   Input channel i_valid / o_stall carries i_mode and i_value; output channel
//   o_valid / i_stall carries o_position, o_total, o_occupancy and o_status.
//   A word moves at a rising edge with valid high and stall low.
//   Every operation gives exactly one result word.
// Operation steps (accept to result valid):
//   push front/back, pop front, read totals, refused ops: result registered at accept.
//   pop back: tail row read from the chain into a register, then word select.
//   find first/last: the match vector of all cells is scanned eight positions
//   per cycle, stopping at the first hit.
// Throughput: one operation in flight; a new word is taken once the current
// one has finished; short operations sustain one word per cycle unless stalled.
// A stalled result word also stalls the input: a new word is taken only at an
// edge where the output register is empty or its word leaves, and an operation
// does not complete while the previous result is still stalled.
// Reset (synchronous, active low) empties the queue and clears the total.
`default_nettype none

module deque_with_search_unit #(
    parameter int DEPTH = 64
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire  [dws_pkg::MODE_W-1:0] i_mode,
    input  wire  signed [dws_pkg::DATA_W-1:0] i_value,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic [dws_pkg::POS_W-1:0]  o_position,
    output logic signed [dws_pkg::DATA_W-1:0] o_total,
    output logic [dws_pkg::POS_W-1:0]  o_occupancy,
    output logic [dws_pkg::STAT_W-1:0] o_status
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int TW   = (IW > dws_pkg::CHUNK_LOG) ? IW : dws_pkg::CHUNK_LOG;
    localparam int NCH  = (DEPTH + dws_pkg::CHUNK - 1) / dws_pkg::CHUNK;
    localparam int NCHW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int MW   = NCH * dws_pkg::CHUNK;
    localparam int SW   = $clog2(MW + 1) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIND  = 2'd1;
    localparam logic [1:0] S_BACK1 = 2'd2;
    localparam logic [1:0] S_BACK2 = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    dws_pkg::t_data         r_sum, n_sum;
    logic [MW-1:0]          r_scan, n_scan;
    logic [NCHW-1:0]        r_cnt, n_cnt;
    logic                   r_last, n_last;
    logic [TW-1:0]          r_tidx, n_tidx;
    logic [dws_pkg::CHUNK-1:0][dws_pkg::DATA_W-1:0] r_row;

    logic                   r_ovalid;
    logic [CW-1:0]          r_opos;
    dws_pkg::t_data         r_ototal;
    logic [CW-1:0]          r_ocount;
    dws_pkg::t_status       r_ostatus;

    dws_pkg::t_cell_ctl     w_ctl;
    dws_pkg::t_data         w_data [DEPTH];
    logic [DEPTH-1:0]       w_occ;
    logic [MW-1:0]          w_hits;
    logic [dws_pkg::CHUNK-1:0][dws_pkg::DATA_W-1:0] w_rows [NCH];
    logic [NCHW-1:0]        w_tchunk;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_oload;
    logic [CW-1:0]          w_opos;
    dws_pkg::t_status       w_ostat;

    logic [dws_pkg::CHUNK-1:0]     w_chunk;
    logic                          w_hit;
    logic [dws_pkg::CHUNK_LOG-1:0] w_idx;
    logic [NCHW-1:0]               w_cidx;
    logic [SW-1:0]                 w_found;
    logic                          w_scan_done;

    // ---------------------------------------------------------------- cell chain
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            dws_pkg::t_data w_prev_data;
            logic           w_prev_occ;
            dws_pkg::t_data w_next_data;
            logic           w_next_occ;
            if (g == 0) begin : g_head
                assign w_prev_data = i_value;
                assign w_prev_occ  = 1'b1;
            end else begin : g_mid
                assign w_prev_data = w_data[g-1];
                assign w_prev_occ  = w_occ[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_next_data = '0;
                assign w_next_occ  = 1'b0;
            end else begin : g_body
                assign w_next_data = w_data[g+1];
                assign w_next_occ  = w_occ[g+1];
            end
            dws_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_key       (i_value),
                .i_value     (i_value),
                .i_prev_data (w_prev_data),
                .i_prev_occ  (w_prev_occ),
                .i_next_data (w_next_data),
                .i_next_occ  (w_next_occ),
                .o_data      (w_data[g]),
                .o_occ       (w_occ[g]),
                .o_hit       (w_hits[g])
            );
        end
        if (MW > DEPTH) begin : g_pad
            assign w_hits[MW-1:DEPTH] = '0;
        end
        for (g = 0; g < MW; g++) begin : g_row
            if (g < DEPTH) begin : g_used
                assign w_rows[g / dws_pkg::CHUNK][g % dws_pkg::CHUNK] = w_data[g];
            end else begin : g_unused
                assign w_rows[g / dws_pkg::CHUNK][g % dws_pkg::CHUNK] = '0;
            end
        end
    endgenerate

    // ---------------------------------------------------------------- scan of match bits
    always_comb begin
        w_chunk = r_last ? r_scan[MW-1 -: dws_pkg::CHUNK] : r_scan[dws_pkg::CHUNK-1:0];
        w_hit   = |w_chunk;
        w_idx   = '0;
        if (r_last) begin
            // highest set bit wins
            for (int j = 0; j < dws_pkg::CHUNK; j++) begin
                if (w_chunk[j]) w_idx = dws_pkg::CHUNK_LOG'(j);
            end
        end else begin
            // lowest set bit wins
            for (int j = dws_pkg::CHUNK - 1; j >= 0; j--) begin
                if (w_chunk[j]) w_idx = dws_pkg::CHUNK_LOG'(j);
            end
        end
        w_cidx      = r_last ? (NCHW'(NCH - 1) - r_cnt) : r_cnt;
        w_found     = (SW'(w_cidx) << dws_pkg::CHUNK_LOG) + SW'(w_idx) + SW'(1);
        w_scan_done = w_hit || (r_cnt == NCHW'(NCH - 1));
    end

    assign w_tchunk = NCHW'(r_tidx >> dws_pkg::CHUNK_LOG);

    // ---------------------------------------------------------------- control
    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_sum   = r_sum;
        n_scan  = r_scan;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_tidx  = r_tidx;
        w_ctl   = '0;
        w_oload = 1'b0;
        w_opos  = '0;
        w_ostat = dws_pkg::STAT_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        dws_pkg::MODE_PUSH_FRONT,
                        dws_pkg::MODE_PUSH_BACK: begin
                            w_oload = 1'b1;
                            if (w_full) begin
                                w_ostat = dws_pkg::STAT_FULL;
                            end else begin
                                w_ctl.push_front = (i_mode == dws_pkg::MODE_PUSH_FRONT);
                                w_ctl.push_back  = (i_mode == dws_pkg::MODE_PUSH_BACK);
                                n_count = r_count + CW'(1);
                                n_sum   = r_sum + i_value;
                            end
                        end
                        dws_pkg::MODE_POP_FRONT: begin
                            w_oload = 1'b1;
                            if (w_empty) begin
                                w_ostat = dws_pkg::STAT_EMPTY;
                            end else begin
                                w_ctl.pop_front = 1'b1;
                                n_count = r_count - CW'(1);
                                n_sum   = r_sum - w_data[0];
                            end
                        end
                        dws_pkg::MODE_POP_BACK: begin
                            if (w_empty) begin
                                w_oload = 1'b1;
                                w_ostat = dws_pkg::STAT_EMPTY;
                            end else begin
                                n_tidx  = TW'(r_count - CW'(1));
                                n_state = S_BACK1;
                            end
                        end
                        dws_pkg::MODE_FIND_FIRST,
                        dws_pkg::MODE_FIND_LAST: begin
                            n_scan  = w_hits;
                            n_cnt   = '0;
                            n_last  = (i_mode == dws_pkg::MODE_FIND_LAST);
                            n_state = S_FIND;
                        end
                        default: begin
                            w_oload = 1'b1;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (w_scan_done) begin
                    if (w_out_free) begin
                        w_oload = 1'b1;
                        w_opos  = w_hit ? CW'(w_found) : '0;
                        n_state = S_IDLE;
                    end
                end else begin
                    // advance to the next group of match bits
                    n_scan = r_last ? (r_scan << dws_pkg::CHUNK) : (r_scan >> dws_pkg::CHUNK);
                    n_cnt  = r_cnt + NCHW'(1);
                end
            end
            S_BACK1: begin
                n_state = S_BACK2;
            end
            S_BACK2: begin
                if (w_out_free) begin
                    w_ctl.pop_back = 1'b1;
                    w_oload = 1'b1;
                    n_count = r_count - CW'(1);
                    n_sum   = r_sum - r_row[r_tidx[dws_pkg::CHUNK_LOG-1:0]];
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_tidx <= n_tidx;
        if (r_state == S_BACK1) begin
            r_row <= w_rows[w_tchunk];
        end
        if (w_oload) begin
            r_opos    <= w_opos;
            r_ototal  <= n_sum;
            r_ocount  <= n_count;
            r_ostatus <= w_ostat;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_position  = dws_pkg::POS_W'(r_opos);
    assign o_total     = r_ototal;
    assign o_occupancy = dws_pkg::POS_W'(r_ocount);
    assign o_status    = r_ostatus;

`ifndef SYNTH
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_occ) == int'(r_count))
        else $error("entry count disagrees with occupied cells");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken while an operation is in progress");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) && (r_ostatus == dws_pkg::STAT_FULL) |-> (r_ocount == CW'(DEPTH)))
        else $error("full refusal reported with room left");
`endif

endmodule

`default_nettype wire
